FILE: src/plra_pkg.sv
// ----------------------------------------------------------------------------
// plra_pkg
// Shared types, constants and codes for the power-limit request arbiter.
// ----------------------------------------------------------------------------
package plra_pkg;

   localparam int POWER_BITS  = 20;
   localparam int NUM_TARGETS = 16;
   localparam int TGT_BITS    = $clog2(NUM_TARGETS);
   localparam int CNT_BITS    = TGT_BITS + 1;
   localparam int TYPE_BITS   = 3;
   localparam int CSR_BITS    = 2;

   // reset values of the control registers
   localparam logic                  RST_CONTROLS = 1'b1;
   localparam logic [POWER_BITS-1:0] RST_MAX_LIMIT = POWER_BITS'(45000);
   localparam logic [POWER_BITS-1:0] RST_MIN_LIMIT = POWER_BITS'(4000);
   localparam logic [POWER_BITS-1:0] RST_STEP_SIZE = POWER_BITS'(500);

   typedef enum logic [TYPE_BITS-1:0] {
      OP_LIMIT   = 3'd0,
      OP_UNLIMIT = 3'd1,
      OP_CLR_TGT = 3'd2,
      OP_CLR_ALL = 3'd3,
      OP_ADJUST  = 3'd4,
      OP_COMMIT  = 3'd5
   } req_op_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_CONTROLS  = 2'd0,
      CSR_MAX_LIMIT = 2'd1,
      CSR_MIN_LIMIT = 2'd2,
      CSR_STEP_SIZE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic [TYPE_BITS-1:0]  req_type;
      logic [3:0]            target;
      logic [POWER_BITS-1:0] average_power;
      logic [POWER_BITS-1:0] programmed_limit;
   } req_word_type;

   typedef struct packed {
      logic [POWER_BITS-1:0] target_request;
      logic [POWER_BITS-1:0] lowest_request;
      logic                  write_limit;
      logic                  request_changed;
   } rsp_word_type;

   typedef struct packed {
      logic                load;
      logic                rd_fetch;
      logic                update;
      logic                rd_sweep;
      logic                fold;
      logic                out_load;
      logic [TGT_BITS-1:0] sweep_idx;
      logic [TGT_BITS-1:0] fold_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_status_type;

endpackage

FILE: src/plra_ram.sv
// ----------------------------------------------------------------------------
// plra_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/plra_ctrl.sv
// ----------------------------------------------------------------------------
// plra_ctrl
// Sequencer: fetch target entry, update it, sweep all entries, emit result.
// ----------------------------------------------------------------------------
module plra_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  plra_pkg::ctl_status_type status,
   output plra_pkg::ctl_cmd_type    cmd
);

   plra_pkg::ctl_state_type         state_ff, state_in;
   logic [plra_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [plra_pkg::CNT_BITS-1:0]   cnt_dec;

   assign cnt_dec = cnt_ff - plra_pkg::CNT_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plra_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.sweep_idx = cnt_ff[plra_pkg::TGT_BITS-1:0];
      cmd.fold_idx  = cnt_dec[plra_pkg::TGT_BITS-1:0];
      case (state_ff)
         plra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = plra_pkg::ST_FETCH;
            end
         end
         plra_pkg::ST_FETCH: begin
            cmd.rd_fetch = 1'b1;
            state_in     = plra_pkg::ST_UPDATE;
         end
         plra_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = plra_pkg::ST_SWEEP;
         end
         plra_pkg::ST_SWEEP: begin
            cmd.rd_sweep = 1'b1;
            cmd.fold     = (cnt_ff != '0);
            cnt_in       = cnt_ff + plra_pkg::CNT_BITS'(1);
            if (cnt_ff == plra_pkg::CNT_BITS'(plra_pkg::NUM_TARGETS - 1)) begin
               state_in = plra_pkg::ST_DRAIN;
            end
         end
         plra_pkg::ST_DRAIN: begin
            cmd.fold = 1'b1;
            state_in = plra_pkg::ST_FINISH;
         end
         plra_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = plra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plra_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/plra_dpath.sv
// ----------------------------------------------------------------------------
// plra_dpath
// Request store, step arithmetic, lowest-request fold and result register.
// ----------------------------------------------------------------------------
module plra_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  plra_pkg::ctl_cmd_type             cmd,
   output plra_pkg::ctl_status_type          status,
   input  plra_pkg::req_word_type            req_word,
   input  logic                              csr_write,
   input  logic [plra_pkg::CSR_BITS-1:0]     csr_index,
   input  logic [plra_pkg::POWER_BITS-1:0]   csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output plra_pkg::rsp_word_type            rsp_word
);

   localparam int P = plra_pkg::POWER_BITS;

   function automatic logic [P-1:0] snap(input logic [P-1:0] v,
                                         input logic [P-1:0] mx,
                                         input logic [P-1:0] mn);
      logic [P-1:0] r;
      r = (v > mx) ? mx : v;
      r = (r < mn) ? mn : r;
      return r;
   endfunction

   // control registers
   logic         ctl_ff;
   logic [P-1:0] max_ff, min_ff, step_ff;

   plra_pkg::req_word_type              word_ff;
   logic [plra_pkg::NUM_TARGETS-1:0]    present_ff;
   logic [P-1:0]                        lo_ff, tgt_val_ff;
   logic                                any_ff, changed_ff;
   logic                                rsp_valid_ff;
   plra_pkg::rsp_word_type              rsp_word_ff;

   logic [plra_pkg::TGT_BITS-1:0] tgt;
   logic [P-1:0]                  rd_data, cur, fv, low_final;
   logic                          is_adjust;

   // step arithmetic
   logic signed [P:0] a_s, b_s, ab_s, min_s;
   logic [P-1:0]      floor_a, floor_ab, down_max, down_val, up_val;
   logic [P:0]        up_sum;
   logic              lim_ok, unl_ok;

   // RAM ports
   logic                          wr_en, rd_en;
   logic [plra_pkg::TGT_BITS-1:0] wr_addr, rd_addr;
   logic [P-1:0]                  wr_data;

   assign tgt       = word_ff.target[plra_pkg::TGT_BITS-1:0];
   assign is_adjust = (word_ff.req_type == plra_pkg::OP_ADJUST);
   assign cur       = present_ff[tgt] ? rd_data : max_ff;

   assign min_s    = $signed({1'b0, min_ff});
   assign a_s      = $signed({1'b0, cur}) - $signed({1'b0, step_ff});
   assign b_s      = $signed({1'b0, word_ff.average_power}) - $signed({1'b0, step_ff});
   assign ab_s     = (a_s < b_s) ? a_s : b_s;
   assign floor_a  = (a_s < min_s) ? min_ff : a_s[P-1:0];
   assign floor_ab = (ab_s < min_s) ? min_ff : ab_s[P-1:0];
   assign down_max = (word_ff.average_power <= min_ff || step_ff > word_ff.average_power)
                     ? min_ff : floor_ab;
   assign down_val = (cur >= max_ff) ? down_max : floor_a;
   assign up_sum   = {1'b0, cur} + {1'b0, step_ff};
   assign up_val   = (up_sum > {1'b0, max_ff}) ? max_ff : up_sum[P-1:0];
   assign lim_ok   = ctl_ff && (cur > min_ff);
   assign unl_ok   = ctl_ff && (cur < max_ff);

   // swept entry, snapped when adjusting
   assign fv = is_adjust ? snap(rd_data, max_ff, min_ff) : rd_data;

   assign low_final = snap(any_ff ? lo_ff : max_ff, max_ff, min_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cmd.fold_idx;
      wr_data = fv;
      if (cmd.update) begin
         wr_addr = tgt;
         if (word_ff.req_type == plra_pkg::OP_LIMIT) begin
            wr_en   = lim_ok;
            wr_data = down_val;
         end else if (word_ff.req_type == plra_pkg::OP_UNLIMIT) begin
            wr_en   = unl_ok;
            wr_data = up_val;
         end
      end else if (cmd.fold) begin
         wr_en = is_adjust && present_ff[cmd.fold_idx];
      end
   end

   assign rd_en   = cmd.rd_fetch | cmd.rd_sweep;
   assign rd_addr = cmd.rd_fetch ? tgt : cmd.sweep_idx;

   plra_ram #(
      .WIDTH (P),
      .DEPTH (plra_pkg::NUM_TARGETS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= plra_pkg::RST_CONTROLS;
         max_ff <= plra_pkg::RST_MAX_LIMIT;
         min_ff <= plra_pkg::RST_MIN_LIMIT;
         step_ff <= plra_pkg::RST_STEP_SIZE;
      end else if (csr_write) begin
         case (plra_pkg::csr_index_type'(csr_index))
            plra_pkg::CSR_CONTROLS:  ctl_ff  <= csr_data[0];
            plra_pkg::CSR_MAX_LIMIT: max_ff  <= csr_data;
            plra_pkg::CSR_MIN_LIMIT: min_ff  <= csr_data;
            plra_pkg::CSR_STEP_SIZE: step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (cmd.update) begin
         case (word_ff.req_type)
            plra_pkg::OP_LIMIT:   if (lim_ok) present_ff[tgt] <= 1'b1;
            plra_pkg::OP_UNLIMIT: if (unl_ok) present_ff[tgt] <= 1'b1;
            plra_pkg::OP_CLR_TGT: present_ff[tgt] <= 1'b0;
            plra_pkg::OP_CLR_ALL: present_ff <= '0;
            default: ;
         endcase
      end
   end

   // payload and fold accumulator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_word;
      end
      if (cmd.update) begin
         lo_ff      <= max_ff;
         any_ff     <= 1'b0;
         changed_ff <= ((word_ff.req_type == plra_pkg::OP_LIMIT) && lim_ok) ||
                       ((word_ff.req_type == plra_pkg::OP_UNLIMIT) && unl_ok);
      end else if (cmd.fold && present_ff[cmd.fold_idx]) begin
         if (!any_ff || fv < lo_ff) begin
            lo_ff <= fv;
         end
         any_ff <= 1'b1;
         if (cmd.fold_idx == tgt) begin
            tgt_val_ff <= fv;
         end
      end
   end

   // result register, frees as soon as the word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_word_ff.target_request  <= present_ff[tgt] ? tgt_val_ff : max_ff;
         rsp_word_ff.lowest_request  <= low_final;
         rsp_word_ff.write_limit     <= (word_ff.req_type == plra_pkg::OP_COMMIT) &&
                                        ctl_ff && (low_final != word_ff.programmed_limit);
         rsp_word_ff.request_changed <= changed_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

endmodule

FILE: src/power_limit_request_arbiter_core.sv
// One request is in work at a time: a new word is taken only once the
// previous result has been loaded into the result register. The wait is
// set by the sweep over all 16 request entries through the single read
// port of the request RAM (one entry per cycle).
// Reset: synchronous, active high; clears all stored requests, restores the
// control registers to their defaults and empties the result register.
// ----------------------------------------------------------------------------
// power_limit_request_arbiter_core
// Keeps one power-limit request per target and arbitrates the lowest one.
// ----------------------------------------------------------------------------
module power_limit_request_arbiter_core (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  plra_pkg::req_word_type           req_word,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output plra_pkg::rsp_word_type           rsp_word,
   // control register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [plra_pkg::CSR_BITS-1:0]    csr_index,
   input  logic [plra_pkg::POWER_BITS-1:0]  csr_data
);

   // Sequence per word:
   //   IDLE   - take the word
   //   FETCH  - read the target's entry
   //   UPDATE - limit/unlimit/clear applied, new value written back
   //   SWEEP  - read each entry; fold into the lowest request, and snap
   //            it back into bounds on an adjust
   //   DRAIN  - fold the last entry
   //   FINISH - load the result register once it is free
   // The result register lets the next word start while the current
   // result still waits on rsp_ready.

   plra_pkg::ctl_cmd_type    cmd;
   plra_pkg::ctl_status_type status;

   // Control writes always taken, unchecked; user must write only while idle.
   assign csr_ready = 1'b1;

   plra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   plra_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the power-limit request arbiter core. Request
// words are streamed through a valid/ready driver with random gaps, and result
// words are drained by a receiver with random stalls and one long hold-off.
// A local copy of the arbitration rules computes the answer for every
// accepted request, and each result word is checked field by field. Control
// registers are rewritten between phases while the core is idle, sweeping
// defaults, controls off, full-range bounds, inverted bounds, a huge step,
// a zero maximum and random bounds.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [plra_pkg::POWER_BITS-1:0] PMAX = {plra_pkg::POWER_BITS{1'b1}};
   // request codes the core has no operation for
   localparam logic [plra_pkg::TYPE_BITS-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [plra_pkg::TYPE_BITS-1:0] OP_RSVD_7 = 3'd7;

   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 30;
   localparam int STALL_LIMIT  = 4000;  // cycles with no word moving at all
   localparam int HOLD_AFTER   = 60;    // result words before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_WORDS  = 130;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_valid  = 1'b0;
   logic                    req_ready;
   plra_pkg::req_word_type  req_word   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready  = 1'b0;
   plra_pkg::rsp_word_type  rsp_word;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   plra_pkg::csr_index_type csr_index  = plra_pkg::CSR_CONTROLS;
   logic [plra_pkg::POWER_BITS-1:0] csr_data = '0;

   power_limit_request_arbiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Local copy of the arbiter: control settings and the per-target requests.
   // Settings change only while the core is idle, so the monitor can read
   // them when a request word is accepted.
   // ---------------------------------------------------------------------------
   bit                              cfg_controls = plra_pkg::RST_CONTROLS;
   logic [plra_pkg::POWER_BITS-1:0] cfg_max      = plra_pkg::RST_MAX_LIMIT;
   logic [plra_pkg::POWER_BITS-1:0] cfg_min      = plra_pkg::RST_MIN_LIMIT;
   logic [plra_pkg::POWER_BITS-1:0] cfg_step     = plra_pkg::RST_STEP_SIZE;

   logic [plra_pkg::POWER_BITS-1:0] level  [plra_pkg::NUM_TARGETS] = '{default: '0};
   bit                              stored [plra_pkg::NUM_TARGETS] = '{default: 1'b0};

   // bench plumbing shared between the processes
   plra_pkg::req_word_type request_backlog[$];   // filled by the sequencer, drained by driver
   plra_pkg::rsp_word_type arbiter_answers[$];   // answers still owed by the core
   bit           req_took      = 1'b0;
   bit           calm          = 1'b0; // no idling on either side
   int           rsp_count     = 0;
   int           mismatch_count = 0;
   int           idle_cycles   = 0;

   // Snap into [min, max]; min wins when the bounds are inverted.
   function automatic logic [plra_pkg::POWER_BITS-1:0] snap_to_bounds(
      logic [plra_pkg::POWER_BITS-1:0] v);
      if (v > cfg_max) v = cfg_max;
      if (v < cfg_min) v = cfg_min;
      return v;
   endfunction

   // Apply one request word to the local copy and return the result word.
   function automatic plra_pkg::rsp_word_type arbitrate_request(plra_pkg::req_word_type w);
      logic [plra_pkg::POWER_BITS-1:0] cur;
      logic [plra_pkg::POWER_BITS-1:0] lo;
      longint                          a;
      longint                          b;
      bit                              any;
      int unsigned                     t;
      plra_pkg::rsp_word_type          r;
      t   = 32'(w.target);
      r   = '0;
      cur = stored[t] ? level[t] : cfg_max;
      case (w.req_type)
         plra_pkg::OP_LIMIT: begin
            if (cfg_controls && cur > cfg_min) begin
               a = longint'(cur) - longint'(cfg_step);
               if (cur >= cfg_max) begin
                  // stepping down from the top: follow the measured power
                  b = longint'(w.average_power) - longint'(cfg_step);
                  if (w.average_power <= cfg_min || cfg_step > w.average_power)
                     a = longint'(cfg_min);
                  else if (b < a)
                     a = b;
               end
               if (a < longint'(cfg_min)) a = longint'(cfg_min);
               level[t]  = plra_pkg::POWER_BITS'(a);
               stored[t] = 1'b1;
               r.request_changed = 1'b1;
            end
         end
         plra_pkg::OP_UNLIMIT: begin
            if (cfg_controls && cur < cfg_max) begin
               a = longint'(cur) + longint'(cfg_step);
               if (a > longint'(cfg_max)) a = longint'(cfg_max);
               level[t]  = plra_pkg::POWER_BITS'(a);
               stored[t] = 1'b1;
               r.request_changed = 1'b1;
            end
         end
         plra_pkg::OP_CLR_TGT: stored[t] = 1'b0;
         plra_pkg::OP_CLR_ALL: stored = '{default: 1'b0};
         plra_pkg::OP_ADJUST: begin
            foreach (level[i])
               if (stored[i]) level[i] = snap_to_bounds(level[i]);
         end
         default: ;
      endcase

      lo  = cfg_max;
      any = 1'b0;
      foreach (level[i]) begin
         if (stored[i] && (!any || level[i] < lo)) begin
            lo  = level[i];
            any = 1'b1;
         end
      end
      r.lowest_request = snap_to_bounds(lo);
      r.write_limit    = (w.req_type == plra_pkg::OP_COMMIT) && cfg_controls &&
                         (r.lowest_request != w.programmed_limit);
      r.target_request = stored[t] ? level[t] : cfg_max;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: one request word at a time from the backlog, changed at the
   // falling edge. Valid stays up with the word frozen until it is taken.
   // ---------------------------------------------------------------------------
   int send_gap   = 0;
   int send_quiet = 0;

   always @(negedge clock) begin
      logic offer;
      offer = 1'b0;
      if (!(req_valid && !req_took)) begin
         if (send_gap > 0)
            send_gap--;
         else if (!calm && send_quiet == 0 && $urandom_range(0, 5) == 0)
            send_gap = $urandom_range(0, 11);   // random burst of idle cycles
         else if (request_backlog.size() != 0) begin
            req_word <= request_backlog.pop_front();
            offer = 1'b1;
         end
         // now and then a stretch with no gaps at all
         if (send_quiet > 0)
            send_quiet--;
         else if ($urandom_range(0, 149) == 0)
            send_quiet = 80;
         req_valid <= offer;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long hold-off while the driver
   // keeps offering, so the result register fills and req_ready drops.
   // ---------------------------------------------------------------------------
   int  stall_left = 0;
   int  hold_left  = 0;
   int  recv_quiet = 0;
   bit  held_once  = 1'b0;

   always @(negedge clock) begin
      logic take;
      take = 1'b0;
      if (hold_left > 0)
         hold_left--;
      else if (!held_once && rsp_count >= HOLD_AFTER) begin
         held_once = 1'b1;
         hold_left = HOLD_CYCLES - 1;
      end else if (stall_left > 0)
         stall_left--;
      else if (!calm && recv_quiet == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(0, 11);
      else
         take = 1'b1;
      if (recv_quiet > 0)
         recv_quiet--;
      else if ($urandom_range(0, 149) == 0)
         recv_quiet = 80;
      rsp_ready <= take;
   end

   // ---------------------------------------------------------------------------
   // Monitor: samples every channel at the rising edge. Results are checked
   // before the new request's answer is queued, so a word that arrives with
   // nothing owed is caught even when a request is taken on the same edge.
   // ---------------------------------------------------------------------------
   task automatic check_field(string field, logic [plra_pkg::POWER_BITS-1:0] want,
                              logic [plra_pkg::POWER_BITS-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result word %0d, %s: expected 0x%0h, got 0x%0h",
                     rsp_count, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      plra_pkg::rsp_word_type want;
      logic                   moved;
      moved = 1'b0;
      req_took <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            rsp_count++;
            if (arbiter_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result word %0d arrived with none owed: %p", rsp_count, rsp_word);
            end else begin
               want = arbiter_answers.pop_front();
               check_field("target_request", want.target_request, rsp_word.target_request);
               check_field("lowest_request", want.lowest_request, rsp_word.lowest_request);
               check_field("write_limit", plra_pkg::POWER_BITS'(want.write_limit),
                           plra_pkg::POWER_BITS'(rsp_word.write_limit));
               check_field("request_changed", plra_pkg::POWER_BITS'(want.request_changed),
                           plra_pkg::POWER_BITS'(rsp_word.request_changed));
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            arbiter_answers.push_back(arbitrate_request(req_word));
         end
         if (csr_valid && csr_ready) moved = 1'b1;
      end
      // watchdog: nothing moving on any channel for too long
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer. Touches the backlog and the settings only in rising-edge time
   // steps; the driver and receiver act on falling edges.
   // ---------------------------------------------------------------------------
   task automatic queue_word(logic [plra_pkg::TYPE_BITS-1:0] op, logic [3:0] t,
                             logic [plra_pkg::POWER_BITS-1:0] avg,
                             logic [plra_pkg::POWER_BITS-1:0] prog);
      plra_pkg::req_word_type w;
      w.req_type         = op;
      w.target           = t;
      w.average_power    = avg;
      w.programmed_limit = prog;
      request_backlog.push_back(w);
   endtask

   // Register write; valid is left high for a following write.
   task automatic csr_write(plra_pkg::csr_index_type idx,
                            logic [plra_pkg::POWER_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         plra_pkg::CSR_CONTROLS:  cfg_controls = value[0];
         plra_pkg::CSR_MAX_LIMIT: cfg_max      = value;
         plra_pkg::CSR_MIN_LIMIT: cfg_min      = value;
         plra_pkg::CSR_STEP_SIZE: cfg_step     = value;
         default: ;
      endcase
   endtask

   task automatic set_limits(bit controls, logic [plra_pkg::POWER_BITS-1:0] hi,
                             logic [plra_pkg::POWER_BITS-1:0] lo,
                             logic [plra_pkg::POWER_BITS-1:0] step);
      csr_write(plra_pkg::CSR_CONTROLS, plra_pkg::POWER_BITS'(controls));
      csr_write(plra_pkg::CSR_MAX_LIMIT, hi);
      csr_write(plra_pkg::CSR_MIN_LIMIT, lo);
      csr_write(plra_pkg::CSR_STEP_SIZE, step);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every word has been sent and answered, then let the core
   // settle before the settings may change.
   task automatic drain;
      while (request_backlog.size() != 0 || req_valid || arbiter_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Power values clustered around the bounds, spread over the current range,
   // kept small (up to twice the step), or anywhere in the field.
   function automatic logic [plra_pkg::POWER_BITS-1:0] pick_power;
      longint base;
      longint span;
      longint x;
      case ($urandom_range(0, 4))
         0: return plra_pkg::POWER_BITS'($urandom);
         1: base = longint'(cfg_min);
         2: base = longint'(cfg_max);
         3: return plra_pkg::POWER_BITS'($urandom_range(0, cfg_max + cfg_max / 4));
         default: return plra_pkg::POWER_BITS'($urandom_range(0, 2 * cfg_step + 8));
      endcase
      span = longint'(cfg_step) * 2 + 3;
      if (span > longint'(PMAX)) span = longint'(PMAX);
      x = base + longint'($urandom_range(0, 2 * span)) - span;
      if (x < 0) x = 0;
      if (x > longint'(PMAX)) x = longint'(PMAX);
      return plra_pkg::POWER_BITS'(x);
   endfunction

   // Mostly limit/unlimit runs on a few targets with commits in between;
   // clears, adjusts and unknown codes are mixed in more rarely.
   task automatic queue_random(int count);
      int                              pick;
      logic [plra_pkg::TYPE_BITS-1:0]  op;
      logic [3:0]                      t;
      logic [plra_pkg::POWER_BITS-1:0] prog;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 34)      op = plra_pkg::OP_LIMIT;
         else if (pick < 58) op = plra_pkg::OP_UNLIMIT;
         else if (pick < 72) op = plra_pkg::OP_COMMIT;
         else if (pick < 79) op = plra_pkg::OP_CLR_TGT;
         else if (pick < 81) op = plra_pkg::OP_CLR_ALL;
         else if (pick < 88) op = plra_pkg::OP_ADJUST;
         else                op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
         t = $urandom_range(0, 2) ? 4'($urandom_range(0, 3))
                                  : 4'($urandom_range(0, plra_pkg::NUM_TARGETS - 1));
         if ($urandom_range(0, 2) == 0)
            prog = $urandom_range(0, 1) ? cfg_min : cfg_max;
         else
            prog = pick_power();
         queue_word(op, t, pick_power(), prog);
      end
   endtask

   initial begin
      logic [plra_pkg::POWER_BITS-1:0] hi;
      logic [plra_pkg::POWER_BITS-1:0] lo;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset settings (max 45000, min 4000, step 500)
      queue_word(plra_pkg::OP_COMMIT,  0, 0, plra_pkg::RST_MAX_LIMIT);  // nothing stored
      queue_word(plra_pkg::OP_COMMIT,  0, PMAX, 0);           // nothing stored, write
      queue_word(plra_pkg::OP_LIMIT,   0, 30000, 0);          // from max, follows avg power
      queue_word(plra_pkg::OP_LIMIT,   0, 0, 0);              // below max, one step down
      queue_word(plra_pkg::OP_LIMIT,   1, 3000, 0);           // avg power under min
      queue_word(plra_pkg::OP_LIMIT,   1, 20000, 0);          // already at min, refused
      queue_word(plra_pkg::OP_LIMIT,   2, 4200, 0);           // floored at min
      queue_word(plra_pkg::OP_LIMIT,   15, PMAX, PMAX);       // avg power far above
      queue_word(plra_pkg::OP_LIMIT,   5, 50000, 0);          // avg above request
      queue_word(plra_pkg::OP_UNLIMIT, 1, 0, 0);
      queue_word(plra_pkg::OP_UNLIMIT, 15, 0, 0);             // reaches max
      queue_word(plra_pkg::OP_UNLIMIT, 15, 0, 0);             // at max, refused
      queue_word(plra_pkg::OP_UNLIMIT, 3, 0, 0);              // absent counts as max
      queue_word(plra_pkg::OP_COMMIT,  0, 0, plra_pkg::RST_MIN_LIMIT);  // equals programmed
      queue_word(plra_pkg::OP_CLR_TGT, 2, 0, 0);
      queue_word(plra_pkg::OP_COMMIT,  0, 0, plra_pkg::RST_MIN_LIMIT);  // moved up, write
      queue_word(plra_pkg::OP_ADJUST,  0, 0, 0);
      queue_word(OP_RSVD_6,  0, PMAX, 0);
      queue_word(OP_RSVD_7,  15, PMAX, PMAX);
      queue_word(plra_pkg::OP_CLR_ALL, 0, 0, 0);
      queue_word(plra_pkg::OP_COMMIT,  0, 0, plra_pkg::RST_MAX_LIMIT);
      queue_random(PHASE_WORDS);
      drain();

      // power control absent: only clears and adjust act
      set_limits(1'b0, plra_pkg::RST_MAX_LIMIT, plra_pkg::RST_MIN_LIMIT,
                 plra_pkg::RST_STEP_SIZE);
      queue_random(PHASE_WORDS);
      drain();

      // widest bounds, zero step
      set_limits(1'b1, PMAX, '0, '0);
      queue_random(PHASE_WORDS);
      drain();

      // inverted bounds: min wins on snapping
      set_limits(1'b1, 20'd2000, 20'd6000, 20'd300);
      queue_random(PHASE_WORDS);
      drain();

      // largest step
      set_limits(1'b1, 20'd60000, 20'd1000, PMAX);
      queue_random(PHASE_WORDS);
      drain();

      // zero maximum and minimum
      set_limits(1'b1, '0, '0, 20'd1);
      queue_random(PHASE_WORDS);
      drain();

      // random bounds, streamed at full rate
      calm = 1'b1;
      hi = plra_pkg::POWER_BITS'($urandom_range(8000, 200000));
      lo = plra_pkg::POWER_BITS'($urandom_range(0, hi));
      set_limits(1'b1, hi, lo, plra_pkg::POWER_BITS'($urandom_range(1, 5000)));
      queue_random(PHASE_WORDS);
      drain();

      if (mismatch_count == 0 && arbiter_answers.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
